// ===== rtl/gqg_pkg.sv =====
`timescale 1ns / 1ps

package gqg_pkg;

  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd2;

  localparam logic [7:0]  FONT_SIZE_RST = 8'd16;
  localparam logic [12:0] ATLAS_DIM_RST = 13'd512;

  // Restoring divider: one quotient bit per step over a 24-bit dividend
  localparam int DIV_STEPS = 24;
  localparam int STEP_W    = 5;

  localparam logic [2:0]  LAST_CORNER = 3'd5;
  localparam logic [16:0] TEX_ONE     = 17'h10000;

  typedef struct packed {
    logic       load;    // word accepted this cycle
    logic       step;    // advance both dividers by one bit
    logic [2:0] corner;  // vertex being presented
  } cmd_t;

  typedef struct packed {
    logic skip;          // incoming word gives no vertices
  } sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// ===== rtl/gqg_ctrl.sv =====
`timescale 1ns / 1ps

module gqg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic              m_tlast,
  input  gqg_pkg::sts_t     sts,
  output gqg_pkg::cmd_t     cmd
);
  import gqg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state, state_next;
  logic [STEP_W-1:0] count, count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.corner = count[2:0];
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          count_next = '0;
          if (!sts.skip) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (count == STEP_W'(DIV_STEPS - 1)) begin
          count_next = '0;
          state_next = ST_EMIT;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (count[2:0] == LAST_CORNER) begin
            count_next = '0;
            state_next = ST_IDLE;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        count_next = '0;
      end
    endcase
  end

  assign m_tlast = m_tvalid && (count[2:0] == LAST_CORNER);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output sides active together");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> count < STEP_W'(DIV_STEPS))
    else $error("divider step count overran");

  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> count[2:0] <= LAST_CORNER)
    else $error("corner out of range");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not idle after last vertex");

  a_quad_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !sts.skip) |=> cmd.step && count == '0)
    else $error("divide did not start after visible glyph");

endmodule

// ===== rtl/gqg_datapath.sv =====
`timescale 1ns / 1ps

module gqg_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gqg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gqg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [gqg_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic [gqg_pkg::IN_USER_W-1:0]       s_tuser,
  input  gqg_pkg::cmd_t                       cmd,
  output gqg_pkg::sts_t                       sts,
  output logic [gqg_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import gqg_pkg::*;

  logic [7:0]  font_size;
  logic [12:0] atlas_width, atlas_height;

  logic signed [15:0] pen_x, pen_y;
  logic signed [15:0] pen_x_next, pen_y_next;

  logic               start, newline;
  logic signed [7:0]  lb, tb;
  logic [7:0]         w, h;
  logic signed [8:0]  ax, ay;
  logic [15:0]        u0_in, v0_in;

  logic signed [15:0] px0, py0;
  logic signed [17:0] l_full, r_full, t_full, b_full;

  // Latched quad geometry
  logic signed [15:0] qx_l, qx_r, qy_t, qy_b;
  logic [15:0]        qu0, qv0;

  // Two restoring dividers, quotient bits shift in at the bottom
  logic [23:0] du_q, dv_q;
  logic [12:0] du_r, dv_r, du_d, dv_d;
  logic [13:0] du_trial, dv_trial;
  logic [13:0] du_diff, dv_diff;

  logic [24:0] u1_sum, v1_sum;
  logic [16:0] u1, v1;

  logic signed [15:0] vx, vy;
  logic [16:0]        vu, vv;

  assign start   = s_tuser[0];
  assign newline = s_tuser[1];
  assign lb      = s_tdata[7:0];
  assign tb      = s_tdata[15:8];
  assign w       = s_tdata[23:16];
  assign h       = s_tdata[31:24];
  assign ax      = s_tdata[40:32];
  assign ay      = s_tdata[49:41];
  assign u0_in   = s_tdata[65:50];
  assign v0_in   = s_tdata[81:66];

  assign sts.skip = newline || (w == 8'd0) || (h == 8'd0);

  assign px0 = start ? 16'sd0 : pen_x;
  assign py0 = start ? 16'sd0 : pen_y;

  assign l_full = 18'(px0) + 18'(lb);
  assign r_full = l_full + $signed({10'd0, w});
  assign t_full = 18'(py0) + 18'(tb);
  assign b_full = t_full - $signed({10'd0, h});

  always_comb begin
    if (newline) begin
      pen_x_next = 16'sd0;
      pen_y_next = sat16(18'(py0) - $signed({10'd0, font_size}));
    end else begin
      pen_x_next = sat16(18'(px0) + 18'(ax));
      pen_y_next = sat16(18'(py0) + 18'(ay));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      font_size    <= FONT_SIZE_RST;
      atlas_width  <= ATLAS_DIM_RST;
      atlas_height <= ATLAS_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FONT_SIZE:    font_size    <= cfg_data[7:0];
        REG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
        REG_ATLAS_HEIGHT: atlas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (cmd.load) begin
      pen_x <= pen_x_next;
      pen_y <= pen_y_next;
    end
  end

  assign du_trial = {du_r, du_q[23]};
  assign dv_trial = {dv_r, dv_q[23]};
  assign du_diff  = du_trial - {1'b0, du_d};
  assign dv_diff  = dv_trial - {1'b0, dv_d};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx_l <= sat16(l_full);
      qx_r <= sat16(r_full);
      qy_t <= sat16(t_full);
      qy_b <= sat16(b_full);
      qu0  <= u0_in;
      qv0  <= v0_in;
      du_q <= {w, 16'd0};
      dv_q <= {h, 16'd0};
      du_r <= '0;
      dv_r <= '0;
      // treat a zero atlas size as one
      du_d <= (atlas_width == 13'd0) ? 13'd1 : atlas_width;
      dv_d <= (atlas_height == 13'd0) ? 13'd1 : atlas_height;
    end else if (cmd.step) begin
      if (du_trial >= {1'b0, du_d}) begin
        du_r <= du_diff[12:0];
        du_q <= {du_q[22:0], 1'b1};
      end else begin
        du_r <= du_trial[12:0];
        du_q <= {du_q[22:0], 1'b0};
      end
      if (dv_trial >= {1'b0, dv_d}) begin
        dv_r <= dv_diff[12:0];
        dv_q <= {dv_q[22:0], 1'b1};
      end else begin
        dv_r <= dv_trial[12:0];
        dv_q <= {dv_q[22:0], 1'b0};
      end
    end
  end

  assign u1_sum = 25'(qu0) + 25'(du_q);
  assign v1_sum = 25'(qv0) + 25'(dv_q);
  assign u1     = (u1_sum > 25'(TEX_ONE)) ? TEX_ONE : u1_sum[16:0];
  assign v1     = (v1_sum > 25'(TEX_ONE)) ? TEX_ONE : v1_sum[16:0];

  always_comb begin
    case (cmd.corner) inside
      3'd0, 3'd3: begin
        vx = qx_r; vy = qy_t; vu = u1;          vv = {1'b0, qv0};
      end
      3'd1: begin
        vx = qx_l; vy = qy_t; vu = {1'b0, qu0}; vv = {1'b0, qv0};
      end
      3'd2, 3'd4: begin
        vx = qx_l; vy = qy_b; vu = {1'b0, qu0}; vv = v1;
      end
      default: begin
        vx = qx_r; vy = qy_b; vu = u1;          vv = v1;
      end
    endcase
  end

  assign m_tdata = {3'd0, cmd.corner, vv, vu, vy, vx};

endmodule

// ===== rtl/glyph_quad_generator_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata glyph metrics, s_tuser start/newline flags
// m_*       out  m_tvalid/m_tready   m_tdata vertex, m_tlast on sixth vertex
// cfg_*     in   cfg_we              cfg_index register, cfg_data value
//
// A newline or an empty bitmap is accepted and the controller stays idle.
// A visible glyph is accepted, passes through the shift-subtract texture
// dividers, then gives six vertex words.
// A stalled m_tready holds the current vertex; no new word is taken until
// the sixth vertex is accepted. Reset is synchronous: pen to origin,
// font_size 16, atlas 512 by 512.

module glyph_quad_generator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // left_bearing[7:0], top_bearing[15:8], bitmap_width[23:16],
  // bitmap_height[31:24], advance_x[40:32], advance_y[49:41],
  // atlas_u[65:50], atlas_v[81:66], zero fill above
  input  logic [gqg_pkg::IN_DATA_W-1:0]       s_tdata,
  // start_of_text[0], is_newline[1]
  input  logic [gqg_pkg::IN_USER_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // vertex_x[15:0], vertex_y[31:16], tex_u[48:32], tex_v[65:49],
  // corner[68:66], zero fill above
  output logic [gqg_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [gqg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gqg_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gqg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gqg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  gqg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tdata   (m_tdata)
  );

endmodule
